>>> design/egf_pkg.sv
// Shared constants and types for the encoder edge glitch filter and burst grouper.
// No dependencies; every other design file imports this package.
`default_nettype none
package egf_pkg;

	localparam int NUM_CHANNELS = 6;
	localparam int TIME_BITS    = 32;
	localparam int CHAN_W       = 3;
	localparam int COUNT_W      = 16;
	localparam int MIN_W        = 8;
	localparam int LVL_W        = NUM_CHANNELS;
	localparam int MAX_RESULTS  = 6;
	localparam int RECS_PER_CH  = 3;
	localparam int NUM_SLOTS    = RECS_PER_CH * NUM_CHANNELS;
	localparam int SLOT_W       = $clog2(NUM_SLOTS);
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GLITCH_TICKS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GROUP_GAP_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_GROUP_EDGES = 2'd2;

	localparam logic [TIME_BITS-1:0] GLITCH_RESET  = TIME_BITS'(25);
	localparam logic [TIME_BITS-1:0] GAP_RESET     = TIME_BITS'(1000);
	localparam logic [MIN_W-1:0]     MIN_RESET     = MIN_W'(5);
	localparam logic [COUNT_W-1:0]   COUNT_MAX     = '1;

	// One burst record without its channel
	typedef struct packed {
		logic               level;
		logic [TIME_BITS-1:0] first;
		logic [TIME_BITS-1:0] last;
		logic [COUNT_W-1:0] count;
	} rec_t;

	// Records a channel can close in one step: edge close, flush keep, flush close
	typedef struct packed {
		logic [RECS_PER_CH-1:0]  vld;
		rec_t [RECS_PER_CH-1:0]  rec;
	} chan_recs_t;

	typedef rec_t [NUM_SLOTS-1:0] slot_recs_t;

	// Thresholds shared by all channels
	typedef struct packed {
		logic [TIME_BITS-1:0] glitch;
		logic [TIME_BITS-1:0] gap;
		logic [MIN_W-1:0]     min_edges;
	} cfg_t;

	// Saturating count increment
	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
	endfunction

endpackage
`default_nettype wire

>>> design/egf_if.sv
// Handshake channel interfaces: sample input, burst record output, config writes.
// Depends on egf_pkg.
`default_nettype none
interface egf_in_if import egf_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [TIME_BITS-1:0] sample_time;
	logic [LVL_W-1:0]     phase_levels;
	logic                 final_sample;

	modport source (output valid, sample_time, phase_levels, final_sample, input ready);
	modport sink (input valid, sample_time, phase_levels, final_sample, output ready);
endinterface

interface egf_out_if import egf_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CHAN_W-1:0]    channel;
	logic                 start_level;
	logic [TIME_BITS-1:0] first_edge_time;
	logic [TIME_BITS-1:0] last_edge_time;
	logic [COUNT_W-1:0]   edge_count;
	logic                 last_of_run;

	modport source (output valid, channel, start_level, first_edge_time, last_edge_time,
		edge_count, last_of_run, input ready);
	modport sink (input valid, channel, start_level, first_edge_time, last_edge_time,
		edge_count, last_of_run, output ready);
endinterface

interface egf_cfg_if import egf_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/encoder_edge_glitch_filter_grouper.sv
// Top level of the encoder edge glitch filter and burst grouper.
// Depends on egf_pkg, egf_if, egf_chan and egf_outq.
//
// Channels: "sample" takes one timestamped item of six phase line levels per
// cycle; "burst" gives burst records; "cfg" writes the glitch time (index 0),
// group gap (index 1) and minimum edge count (index 2), always ready.
// An accepted item sits in an input register; from there it is filtered
// and grouped in one pass over all six channels and its records, up to six,
// are loaded into a record buffer, from which the first record is offered;
// the rest follow one per cycle while the receiver is ready, in order, the
// last one flagged with last_of_run.
// Throughput: one item per cycle. An item that produces records waits in the
// input register while an earlier item's records are still in the buffer,
// short of the cycle in which the last of them is taken; items with no
// records keep flowing. When the receiver stalls, the buffer holds, the next
// item with records stays in the input register and sample.ready drops.
// Reset: thresholds return to 25, 1000 and 5, all run state is cleared and
// the next item is taken as the reference sample.
`default_nettype none
module encoder_edge_glitch_filter_grouper import egf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	egf_in_if.sink    sample,
	egf_out_if.source burst,
	egf_cfg_if.sink   cfg
);

	cfg_t                 cfg_q;
	logic                 vld_s1;
	logic [TIME_BITS-1:0] time_s1;
	logic [LVL_W-1:0]     lvl_s1;
	logic                 fin_s1;
	logic [LVL_W-1:0]     prev_q;
	logic                 have_prev_q;

	chan_recs_t           chan_recs [NUM_CHANNELS];
	logic [NUM_SLOTS-1:0] flags;
	slot_recs_t           slot_recs;
	logic                 busy;
	logic                 advance;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.glitch    <= GLITCH_RESET;
			cfg_q.gap       <= GAP_RESET;
			cfg_q.min_edges <= MIN_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_GLITCH_TICKS:    cfg_q.glitch    <= cfg.data[TIME_BITS-1:0];
				REG_GROUP_GAP_TICKS: cfg_q.gap       <= cfg.data[TIME_BITS-1:0];
				REG_MIN_GROUP_EDGES: cfg_q.min_edges <= cfg.data[MIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register; an item with records waits for an empty buffer
	assign advance      = vld_s1 && (!(|flags) || !busy);
	assign sample.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (sample.ready) begin
			vld_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			time_s1 <= sample.sample_time;
			lvl_s1  <= sample.phase_levels;
			fin_s1  <= sample.final_sample;
		end
	end

	// Reference levels; a final sample starts a new capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			have_prev_q <= 1'b0;
		end else if (advance) begin
			prev_q      <= fin_s1 ? '0 : lvl_s1;
			have_prev_q <= !fin_s1;
		end
	end

	// Channel cells; channel c sits on level bit NUM_CHANNELS-1-c
	for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
		egf_chan u_chan (
			.clk      (clk),
			.arst_n   (arst_n),
			.step     (advance),
			.edge_det (have_prev_q &&
				(lvl_s1[NUM_CHANNELS-1-c] != prev_q[NUM_CHANNELS-1-c])),
			.now_lvl  (lvl_s1[NUM_CHANNELS-1-c]),
			.fin      (fin_s1),
			.t        (time_s1),
			.cfg      (cfg_q),
			.recs     (chan_recs[c])
		);

		// Edge-phase records first, then each channel's flush records
		assign flags[c]                    = chan_recs[c].vld[0];
		assign slot_recs[c]                = chan_recs[c].rec[0];
		assign flags[NUM_CHANNELS+2*c]     = chan_recs[c].vld[1];
		assign slot_recs[NUM_CHANNELS+2*c] = chan_recs[c].rec[1];
		assign flags[NUM_CHANNELS+2*c+1]     = chan_recs[c].vld[2];
		assign slot_recs[NUM_CHANNELS+2*c+1] = chan_recs[c].rec[2];
	end

	egf_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && (|flags)),
		.flags  (flags),
		.recs   (slot_recs),
		.busy   (busy),
		.burst  (burst)
	);

endmodule
`default_nettype wire

>>> design/egf_chan.sv
// One phase channel: pending edge glitch filter, burst grouper and flush on final sample.
// Depends on egf_pkg.
`default_nettype none
module egf_chan import egf_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic                 edge_det,
	input  wire logic                 now_lvl,
	input  wire logic                 fin,
	input  wire logic [TIME_BITS-1:0] t,
	input  wire cfg_t                 cfg,
	output chan_recs_t                recs
);

	// Channel state
	logic                 pv_q, bo_q, pl_q, blv_q;
	logic [TIME_BITS-1:0] pt_q, bf_q, bl_q;
	logic [COUNT_W-1:0]   cnt_q;

	// State after the edge phase (a) and after the flush keep (b)
	logic                 pv_a, pl_a, bo_a, blv_a, kept_a;
	logic [TIME_BITS-1:0] pt_a, bf_a, bl_a;
	logic [COUNT_W-1:0]   cnt_a;
	logic                 bo_b, blv_b;
	logic [TIME_BITS-1:0] bf_b, bl_b;
	logic [COUNT_W-1:0]   cnt_b;

	logic [TIME_BITS-1:0] d, gap_a, gap_tb, gap_b;
	logic [COUNT_W-1:0]   min_ext;

	// Differences are all taken in parallel from the stored state
	assign d       = t - pt_q;
	assign gap_a   = pt_q - bl_q;
	assign gap_tb  = t - bl_q;
	assign min_ext = COUNT_W'(cfg.min_edges);

	always_comb begin
		// edge phase
		pv_a   = pv_q;
		pt_a   = pt_q;
		pl_a   = pl_q;
		bo_a   = bo_q;
		bf_a   = bf_q;
		bl_a   = bl_q;
		blv_a  = blv_q;
		cnt_a  = cnt_q;
		kept_a = 1'b0;
		recs.vld = '0;
		if (edge_det) begin
			if (pv_q && (d < cfg.glitch)) begin
				pv_a = 1'b0;
			end else begin
				if (pv_q) begin
					kept_a = 1'b1;
					if (bo_q && (gap_a <= cfg.gap)) begin
						bl_a  = pt_q;
						cnt_a = sat_inc(cnt_q);
					end else begin
						recs.vld[0] = bo_q && (cnt_q >= min_ext);
						bo_a  = 1'b1;
						bf_a  = pt_q;
						bl_a  = pt_q;
						blv_a = pl_q;
						cnt_a = COUNT_W'(1);
					end
				end
				pv_a = 1'b1;
				pt_a = t;
				pl_a = now_lvl;
			end
		end
		recs.rec[0] = '{level: blv_q, first: bf_q, last: bl_q, count: cnt_q};

		// flush: the pending edge passes unfiltered
		// its gap is the glitch difference when the edge phase just kept an edge
		gap_b = kept_a ? d : (edge_det ? gap_tb : gap_a);
		bo_b  = bo_a;
		bf_b  = bf_a;
		bl_b  = bl_a;
		blv_b = blv_a;
		cnt_b = cnt_a;
		if (fin && pv_a) begin
			if (bo_a && (gap_b <= cfg.gap)) begin
				bl_b  = pt_a;
				cnt_b = sat_inc(cnt_a);
			end else begin
				recs.vld[1] = bo_a && (cnt_a >= min_ext);
				bo_b  = 1'b1;
				bf_b  = pt_a;
				bl_b  = pt_a;
				blv_b = pl_a;
				cnt_b = COUNT_W'(1);
			end
		end
		recs.rec[1] = '{level: blv_a, first: bf_a, last: bl_a, count: cnt_a};

		// flush: the open burst closes
		recs.vld[2] = fin && bo_b && (cnt_b >= min_ext);
		recs.rec[2] = '{level: blv_b, first: bf_b, last: bl_b, count: cnt_b};
	end

	// Control state; a final sample returns it to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q  <= 1'b0;
			bo_q  <= 1'b0;
			cnt_q <= '0;
		end else if (step) begin
			pv_q  <= fin ? 1'b0 : pv_a;
			bo_q  <= fin ? 1'b0 : bo_a;
			cnt_q <= fin ? '0 : cnt_a;
		end
	end

	// Payload state, read only while its valid flag is set
	always_ff @(posedge clk) begin
		if (step) begin
			pt_q  <= pt_a;
			pl_q  <= pl_a;
			bf_q  <= bf_a;
			bl_q  <= bl_a;
			blv_q <= blv_a;
		end
	end

endmodule
`default_nettype wire

>>> design/egf_outq.sv
// Record batch buffer: holds the records of one sample and sends them out in order.
// Depends on egf_pkg and egf_if.
`default_nettype none
module egf_outq import egf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire logic [NUM_SLOTS-1:0]  flags,
	input  wire slot_recs_t            recs,
	output logic                       busy,
	egf_out_if.source                  burst
);

	logic [NUM_SLOTS-1:0] mask_q;
	slot_recs_t           slot_q;

	logic [NUM_SLOTS-1:0] capped;
	logic [NUM_SLOTS-1:0] sel_oh;
	logic [SLOT_W-1:0]    sel;
	logic [CHAN_W-1:0]    sel_chan;
	logic                 found;

	// Keep only the first records of the step
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			capped[i] = flags[i] &&
				($countones(flags & ((NUM_SLOTS'(1) << i) - NUM_SLOTS'(1))) < MAX_RESULTS);
		end
	end

	// Lowest pending slot goes out first; slot order is record order
	always_comb begin
		sel      = '0;
		sel_chan = '0;
		found    = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (mask_q[i] && !found) begin
				found = 1'b1;
				sel   = SLOT_W'(i);
				if (i < NUM_CHANNELS)
					sel_chan = CHAN_W'(i);
				else
					sel_chan = CHAN_W'((i - NUM_CHANNELS) >> 1);
			end
		end
	end

	assign sel_oh = NUM_SLOTS'(1) << sel;

	// A new batch may load in the cycle the last record of the old one is taken
	assign busy   = (|mask_q) && !(burst.ready && burst.last_of_run);

	assign burst.valid           = |mask_q;
	assign burst.channel         = sel_chan;
	assign burst.start_level     = slot_q[sel].level;
	assign burst.first_edge_time = slot_q[sel].first;
	assign burst.last_edge_time  = slot_q[sel].last;
	assign burst.edge_count      = slot_q[sel].count;
	assign burst.last_of_run     = ((mask_q & ~sel_oh) == '0);

	// Batch is loaded only when empty or emptying
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= capped;
		end else if (burst.valid && burst.ready) begin
			mask_q <= mask_q & ~sel_oh;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			slot_q <= recs;
	end

endmodule
`default_nettype wire
